/* hw/rtl/pcal_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcal_pkg
// Shared types, constants and the saturation helper for the polynomial
// calibration block.
// ----------------------------------------------------------------------------
package pcal_pkg;

  localparam int Q_W            = 32;  // signed Q16.16 field width
  localparam int FRAC_BITS      = 16;
  localparam int PROD_W         = 2 * Q_W;
  localparam int SUM_W          = PROD_W - FRAC_BITS + 1;
  localparam int COEFF_SLOTS    = 6;
  localparam int N_W            = 3;
  localparam int ADDR_W         = 5;
  localparam int APB_W          = 32;
  localparam int MAX_COEFFS_DEF = 6;
  localparam int DATA_WIDTH     = 32;
  localparam int SAT_W          = (DATA_WIDTH < Q_W) ? DATA_WIDTH : Q_W;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [N_W-1:0]        n_t;
  typedef logic [2:0]            reg_idx_t;

  localparam reg_idx_t REG_ORIGIN = 3'd0;
  localparam reg_idx_t REG_COUNT  = 3'd1;
  localparam reg_idx_t REG_COEFF0 = 3'd2;

  localparam q_t COEFF1_RESET = 32'sd65536;  // 1.0

  typedef struct packed {
    q_t                     origin;
    n_t                     count;
    q_t [COEFF_SLOTS-1:0]   coeff;
  } cfg_t;

  // One sample moving down the chain
  typedef struct packed {
    logic last;
    logic sat;
    n_t   n;
    q_t   x;
    q_t   acc;
  } tok_t;

  typedef struct packed {
    logic clip;
    q_t   val;
  } sat_t;

  function automatic sat_t sat_q(input logic signed [SUM_W-1:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.clip = 1'b1;
      r.val  = SAT_HI[Q_W-1:0];
    end else if (v < SAT_LO) begin
      r.clip = 1'b1;
      r.val  = SAT_LO[Q_W-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/pcal_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcal_in_if
// Sample channel: valid/ready with one raw sample and its last marker.
// ----------------------------------------------------------------------------
interface pcal_in_if;
  logic           valid;
  logic           ready;
  pcal_pkg::q_t   sample;
  logic           last_in;

  modport source (output valid, output sample, output last_in, input ready);
  modport sink   (input valid, input sample, input last_in, output ready);
endinterface

/* hw/rtl/pcal_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcal_out_if
// Result channel: valid/ready with the calibrated value and its flags.
// ----------------------------------------------------------------------------
interface pcal_out_if;
  logic           valid;
  logic           ready;
  pcal_pkg::q_t   value;
  logic           saturated;
  logic           last_out;

  modport source (output valid, output value, output saturated, output last_out,
                  input ready);
  modport sink   (input valid, input value, input saturated, input last_out,
                  output ready);
endinterface

/* hw/rtl/pcal_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcal_regs
// APB register file: origin, coefficient count and six coefficients.
// ----------------------------------------------------------------------------
module pcal_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcal_pkg::ADDR_W-1:0]    paddr,
  input  logic [pcal_pkg::APB_W-1:0]     pwdata,
  output logic [pcal_pkg::APB_W-1:0]     prdata,
  output logic                           pready,
  output pcal_pkg::cfg_t                 cfg
);
  import pcal_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin <= '0;
      cfg.count  <= '0;
      cfg.coeff[0] <= '0;
      cfg.coeff[1] <= COEFF1_RESET;
      cfg.coeff[COEFF_SLOTS-1:2] <= '0;
    end else if (wr) begin
      case (idx)
        REG_ORIGIN: cfg.origin <= pwdata[Q_W-1:0];
        REG_COUNT:  cfg.count  <= pwdata[N_W-1:0];
        default:    cfg.coeff[idx - REG_COEFF0] <= pwdata[Q_W-1:0];
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN: prdata = APB_W'(cfg.origin);
      REG_COUNT:  prdata = APB_W'(cfg.count);
      default:    prdata = APB_W'(cfg.coeff[idx - REG_COEFF0]);
    endcase
  end

endmodule

/* hw/rtl/pcal_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcal_front
// Head of the chain: removes the origin, clips x and loads the top
// coefficient as the starting Horner accumulator, or x itself at count 0.
// ----------------------------------------------------------------------------
module pcal_front #(
  parameter int MAX_COEFFS = pcal_pkg::MAX_COEFFS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcal_pkg::q_t         sample,
  input  logic                 last_in,
  input  pcal_pkg::cfg_t       cfg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pcal_pkg::tok_t       out_tok
);
  import pcal_pkg::*;

  n_t                       n_eff;
  logic signed [SUM_W-1:0]  diff;
  sat_t                     xs;
  sat_t                     cs;
  q_t                       top_c;
  tok_t                     tok_next;

  assign n_eff = (cfg.count > N_W'(MAX_COEFFS)) ? N_W'(MAX_COEFFS) : cfg.count;
  assign diff  = SUM_W'(sample) - SUM_W'(cfg.origin);
  assign xs    = sat_q(diff);

  // coefficient n-1 opens the Horner recurrence
  always_comb begin
    top_c = '0;
    for (int j = 0; j < COEFF_SLOTS; j++) begin
      if (N_W'(j + 1) == n_eff) top_c = cfg.coeff[j];
    end
  end

  assign cs = sat_q(SUM_W'(top_c));

  always_comb begin
    tok_next.last = last_in;
    tok_next.n    = n_eff;
    tok_next.x    = xs.val;
    tok_next.acc  = (n_eff == '0) ? xs.val : cs.val;
    tok_next.sat  = ((n_eff != N_W'(1)) && xs.clip) || ((n_eff != '0) && cs.clip);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_tok <= tok_next;
    end
  end

endmodule

/* hw/rtl/pcal_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcal_cell
// One Horner step: acc = sat(floor(acc * x / 2^16) + coeff[IDX]).
// Two stages: registered product, then shift, add and saturate.
// Passes the token unchanged unless IDX lies below the top coefficient in use.
// ----------------------------------------------------------------------------
module pcal_cell #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pcal_pkg::q_t         coeff,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcal_pkg::tok_t       in_tok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pcal_pkg::tok_t       out_tok
);
  import pcal_pkg::*;

  logic                      mul_valid;
  logic                      mul_ready;
  tok_t                      mul_tok;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_next;
  logic                      active;
  logic signed [SUM_W-1:0]   sum;
  sat_t                      ss;
  tok_t                      tok_next;

  assign prod_next = in_tok.acc * in_tok.x;

  assign mul_ready = !out_valid || out_ready;
  assign in_ready  = !mul_valid || mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (in_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      mul_tok <= in_tok;
      prod    <= prod_next;
    end
  end

  // active while this coefficient is below the top one in use
  assign active = (mul_tok.n > N_W'(IDX + 1));
  assign sum    = SUM_W'(prod >>> FRAC_BITS) + SUM_W'(coeff);
  assign ss     = sat_q(sum);

  always_comb begin
    tok_next = mul_tok;
    if (active) begin
      tok_next.acc = ss.val;
      tok_next.sat = mul_tok.sat || ss.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mul_ready) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready) begin
      out_tok <= tok_next;
    end
  end

endmodule

/* hw/rtl/polynomial_calibration.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_calibration
// Usage: samples arrive on the upstream valid/ready channel, results leave on
// the downstream channel, one result per sample, in order. Each sample has
// the origin removed and is run through a Horner polynomial of up to
// MAX_COEFFS terms in signed Q16.16, saturating each partial sum.
// Configuration goes over the APB port (origin, count, coeff_0..coeff_5 at
// byte addresses 0x00..0x1C); write it only while no sample is in flight.
// Throughput: one sample per cycle while downstream takes results. Depth:
// 2*MAX_COEFFS-1 register stages (11 at the default): one front stage plus
// a two-stage cell (multiply, then add and saturate) per Horner step.
// Reset clears the pipeline and loads coeff_1 = 1.0, all other registers 0.
// When downstream stalls, the last stage holds its result while earlier
// stages keep filling; upstream ready drops only once every stage is full.
// ----------------------------------------------------------------------------
module polynomial_calibration #(
  parameter int MAX_COEFFS = pcal_pkg::MAX_COEFFS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcal_pkg::ADDR_W-1:0]    paddr,
  input  logic [pcal_pkg::APB_W-1:0]     pwdata,
  output logic [pcal_pkg::APB_W-1:0]     prdata,
  output logic                           pready,
  pcal_in_if.sink                        upstream,
  pcal_out_if.source                     downstream
);
  import pcal_pkg::*;

  cfg_t  cfg;
  tok_t  stg_tok   [MAX_COEFFS];
  logic  stg_valid [MAX_COEFFS];
  logic  stg_ready [MAX_COEFFS];

  pcal_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcal_front #(
    .MAX_COEFFS (MAX_COEFFS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (upstream.valid),
    .in_ready  (upstream.ready),
    .sample    (upstream.sample),
    .last_in   (upstream.last_in),
    .cfg       (cfg),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_tok   (stg_tok[0])
  );

  // cell k applies coefficient MAX_COEFFS-2-k
  for (genvar k = 0; k < MAX_COEFFS - 1; k++) begin : g_cell
    pcal_cell #(
      .IDX (MAX_COEFFS - 2 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .coeff     (cfg.coeff[MAX_COEFFS - 2 - k]),
      .in_valid  (stg_valid[k]),
      .in_ready  (stg_ready[k]),
      .in_tok    (stg_tok[k]),
      .out_valid (stg_valid[k+1]),
      .out_ready (stg_ready[k+1]),
      .out_tok   (stg_tok[k+1])
    );
  end

  assign stg_ready[MAX_COEFFS-1] = downstream.ready;
  assign downstream.valid        = stg_valid[MAX_COEFFS-1];
  assign downstream.value        = stg_tok[MAX_COEFFS-1].acc;
  assign downstream.saturated    = stg_tok[MAX_COEFFS-1].sat;
  assign downstream.last_out     = stg_tok[MAX_COEFFS-1].last;

endmodule
